[src/lru_or_brrip_victim_select_top_defines.svh]
// ----------------------------------------------------------------------------
// Replacement victim select - assertion macros
// Shared concurrent assertion forms for the victim select block.
// ----------------------------------------------------------------------------
`ifndef LRU_OR_BRRIP_VICTIM_SELECT_TOP_DEFINES_SVH
`define LRU_OR_BRRIP_VICTIM_SELECT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define LOVS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LOVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lovs_pkg.sv]
// ----------------------------------------------------------------------------
// Replacement victim select - package
// Field widths, defaults, request kinds and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lovs_pkg;

    // Field widths
    localparam int KIND_W     = 2;
    localparam int SET_W      = 6;
    localparam int WAY_W      = 3;
    localparam int STAMP_W    = 32;
    localparam int PCT_W      = 7;
    localparam int VWAY_W     = 3;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Default geometry
    localparam int DEF_SETS      = 64;
    localparam int DEF_WAYS      = 8;
    localparam int DEF_RRPV_BITS = 2;

    // Register reset values
    localparam logic [PCT_W-1:0] INS_PROB_RST = 7'd3;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INVAL  = 2'd0,
        KIND_TOUCH  = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_FIND   = 2'd3
    } t_kind;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLICY   = 2'd0,
        REG_HIT_PRIO = 2'd1,
        REG_INS_PROB = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

[src/lovs_ram.sv]
// ----------------------------------------------------------------------------
// Replacement victim select - generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lovs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/lru_or_brrip_victim_select_top.sv]
// ----------------------------------------------------------------------------
// Replacement victim select - top level
// Replacement-state keeper for a set-associative cache, in LRU (time stamp) or
// bimodal RRIP mode. Every way of every set has one entry of stamp, RRPV and
// valid bit in a RAM with one read and one write port; a small sequencer walks
// the ways of a set one per cycle. An invalidate, touch or insert is a
// read-modify-write of one entry. A find victim reads the ways of the set in
// turn, and in RRIP mode stops early when an invalid way turns up before the
// last way; in RRIP mode, when no way is invalid and no way holds the maximum
// RRPV, an ageing pass then rewrites every way. A request runs to its end
// before the next is accepted; while a result is held, the next request waits
// in its last state until the result goes. After reset the block clears the
// RAM one entry per cycle, all SETS*WAYS entries (512 by default), before it
// accepts its first transaction; configuration writes are taken throughout.
// Every request returns one result; victim_ready (tuser) marks the answer to
// a find victim.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_or_brrip_victim_select_top_defines.svh"

module lru_or_brrip_victim_select_top
    import lovs_pkg::*;
#(
    parameter int SETS      = DEF_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int RRPV_BITS = DEF_RRPV_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // set_index [5:0], way [8:6], time_stamp [40:9], rand_percent [47:41]
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // kind [1:0]
    input  wire logic [KIND_W-1:0]     s_axis_tuser,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // victim_way [2:0], zero fill [7:3]
    output logic      [M_TDATA_W-1:0]  m_axis_tdata,
    // victim_ready [0]
    output logic                       m_axis_tuser,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ENTRIES = SETS * WAYS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(WAYS + 1);
    localparam int WIX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_W   = SET_W + CNT_W;
    localparam int ENT_W   = STAMP_W + RRPV_BITS + 1;
    localparam logic [RRPV_BITS-1:0] RRPV_MAX  = '1;
    localparam logic [CNT_W-1:0]     WAYS_CNT  = CNT_W'(WAYS);
    localparam logic [WIX_W-1:0]     LAST_WAY  = WIX_W'(WAYS - 1);
    localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW_RD,
        S_RMW_WR,
        S_SCAN,
        S_AGE,
        S_DONE
    } t_state;

    // entry address of a way within a set
    function automatic logic [ADDR_W-1:0] f_addr(input logic [SET_W-1:0] set,
                                                 input logic [CNT_W-1:0] way);
        logic [IDX_W-1:0]        idx;
        logic [ADDR_W+IDX_W-1:0] wide;
        idx  = IDX_W'(set) * IDX_W'(WAYS) + IDX_W'(way);
        wide = {{ADDR_W{1'b0}}, idx};
        return wide[ADDR_W-1:0];
    endfunction

    // registers
    t_state               r_state, n_state;
    t_kind                r_kind, n_kind;
    logic [SET_W-1:0]     r_set, n_set;
    logic [WAY_W-1:0]     r_way, n_way;
    logic [STAMP_W-1:0]   r_stamp, n_stamp;
    logic [PCT_W-1:0]     r_draw, n_draw;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_pend, n_pend;
    logic [WIX_W-1:0]     r_dway, n_dway;
    logic [WIX_W-1:0]     r_best, n_best;
    logic [STAMP_W-1:0]   r_best_stamp, n_best_stamp;
    logic [RRPV_BITS-1:0] r_best_rrpv, n_best_rrpv;
    logic [RRPV_BITS-1:0] r_gap, n_gap;
    logic                 r_find, n_find;
    logic [ADDR_W-1:0]    r_clr, n_clr;
    logic                 r_out_valid, n_out_valid;
    logic [VWAY_W-1:0]    r_out_way, n_out_way;
    logic                 r_out_flag, n_out_flag;
    logic                 r_mode, n_mode;
    logic                 r_hit_prio, n_hit_prio;
    logic [PCT_W-1:0]     r_ins_prob, n_ins_prob;

    // RAM ports
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ENT_W-1:0]     ram_rdata;

    // helpers
    logic                 s_accept;
    t_kind                s_kind;
    logic [SET_W-1:0]     s_set;
    logic [WAY_W-1:0]     s_way;
    logic                 s_set_oor;
    logic                 s_way_oor;
    logic [CNT_W+WAY_W-1:0] way_ext;
    logic [CNT_W-1:0]     way_cnt;
    logic [CNT_W+WIX_W-1:0] dway_ext;
    logic [CNT_W-1:0]     dway_cnt;
    logic [WIX_W+VWAY_W-1:0] best_ext;
    logic [STAMP_W-1:0]   q_stamp;
    logic [RRPV_BITS-1:0] q_rrpv;
    logic                 q_valid;
    logic [RRPV_BITS:0]   age_sum;
    logic [RRPV_BITS-1:0] aged_rrpv;
    logic [RRPV_BITS-1:0] mod_rrpv;
    logic [STAMP_W-1:0]   mod_stamp;
    logic                 mod_valid;
    logic                 d_last;

    lovs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // input unpacking and range checks
    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign s_kind    = t_kind'(s_axis_tuser);
    assign s_set     = s_axis_tdata[SET_W-1:0];
    assign s_way     = s_axis_tdata[SET_W +: WAY_W];
    assign s_set_oor = 32'(s_set) >= 32'(SETS);
    assign s_way_oor = 32'(s_way) >= 32'(WAYS);

    assign way_ext   = {{CNT_W{1'b0}}, r_way};
    assign way_cnt   = way_ext[CNT_W-1:0];
    assign dway_ext  = {{CNT_W{1'b0}}, r_dway};
    assign dway_cnt  = dway_ext[CNT_W-1:0];
    assign best_ext  = {{VWAY_W{1'b0}}, r_best};
    assign d_last    = (r_dway == LAST_WAY);

    // entry fields of the read data
    assign q_stamp   = ram_rdata[STAMP_W-1:0];
    assign q_rrpv    = ram_rdata[STAMP_W +: RRPV_BITS];
    assign q_valid   = ram_rdata[ENT_W-1];

    // saturating ageing add
    assign age_sum   = {1'b0, q_rrpv} + {1'b0, r_gap};
    assign aged_rrpv = (age_sum > {1'b0, RRPV_MAX}) ? RRPV_MAX : age_sum[RRPV_BITS-1:0];

    // single-entry update for invalidate, touch and insert
    always_comb begin
        mod_stamp = q_stamp;
        mod_rrpv  = q_rrpv;
        mod_valid = q_valid;
        if (!r_mode) begin
            mod_stamp = (r_kind == KIND_INVAL) ? '0 : r_stamp;
        end else begin
            unique case (r_kind)
                KIND_INVAL: begin
                    mod_valid = 1'b0;
                end
                KIND_TOUCH: begin
                    if (r_hit_prio) begin
                        mod_rrpv = '0;
                    end else if (q_rrpv != '0) begin
                        mod_rrpv = q_rrpv - 1'b1;
                    end
                end
                KIND_INSERT: begin
                    mod_rrpv  = (r_draw <= r_ins_prob) ? RRPV_MAX - 1'b1 : RRPV_MAX;
                    mod_valid = 1'b1;
                end
                default: begin
                    mod_valid = q_valid;
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_set        = r_set;
        n_way        = r_way;
        n_stamp      = r_stamp;
        n_draw       = r_draw;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        n_dway       = r_dway;
        n_best       = r_best;
        n_best_stamp = r_best_stamp;
        n_best_rrpv  = r_best_rrpv;
        n_gap        = r_gap;
        n_find       = r_find;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_way    = r_out_way;
        n_out_flag   = r_out_flag;
        n_mode       = r_mode;
        n_hit_prio   = r_hit_prio;
        n_ins_prob   = r_ins_prob;
        ram_we       = 1'b0;
        ram_waddr    = f_addr(r_set, dway_cnt);
        ram_wdata    = {q_valid, aged_rrpv, q_stamp};
        ram_re       = 1'b0;
        ram_raddr    = f_addr(r_set, r_cnt);

        // configuration writes
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_POLICY:   n_mode     = i_cfg_data[0];
                REG_HIT_PRIO: n_hit_prio = i_cfg_data[0];
                REG_INS_PROB: n_ins_prob = i_cfg_data;
                default:      n_mode     = r_mode;
            endcase
        end

        unique case (r_state)
            // zero every entry after reset
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_kind  = s_kind;
                    n_set   = s_set;
                    n_way   = s_way;
                    n_stamp = s_axis_tdata[SET_W+WAY_W +: STAMP_W];
                    n_draw  = s_axis_tdata[SET_W+WAY_W+STAMP_W +: PCT_W];
                    n_find  = (s_kind == KIND_FIND);
                    n_best  = '0;
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    if (s_kind == KIND_FIND) begin
                        n_state = s_set_oor ? S_DONE : S_SCAN;
                    end else begin
                        n_state = (s_set_oor || s_way_oor) ? S_DONE : S_RMW_RD;
                    end
                end
            end
            S_RMW_RD: begin
                ram_re    = 1'b1;
                ram_raddr = f_addr(r_set, way_cnt);
                n_state   = S_RMW_WR;
            end
            S_RMW_WR: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(r_set, way_cnt);
                ram_wdata = {mod_valid, mod_rrpv, mod_stamp};
                n_state   = S_DONE;
            end
            // walk the ways of the set, one read per cycle
            S_SCAN: begin
                n_pend = 1'b0;
                if (r_cnt != WAYS_CNT) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_pend = 1'b1;
                    n_dway = r_cnt[WIX_W-1:0];
                end
                if (r_pend) begin
                    if (!r_mode) begin
                        if (r_dway == '0 || q_stamp < r_best_stamp) begin
                            n_best       = r_dway;
                            n_best_stamp = q_stamp;
                        end
                        if (d_last) begin
                            n_state = S_DONE;
                        end
                    end else if (!q_valid) begin
                        n_best  = r_dway;
                        n_state = S_DONE;
                    end else begin
                        if (r_dway == '0 || q_rrpv > r_best_rrpv) begin
                            n_best      = r_dway;
                            n_best_rrpv = q_rrpv;
                        end
                        if (d_last) begin
                            n_gap = RRPV_MAX - n_best_rrpv;
                            if (n_gap != '0) begin
                                n_state = S_AGE;
                                n_cnt   = '0;
                                n_pend  = 1'b0;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                    end
                end
            end
            // age every way of the set by the gap, reading one way while writing back the one read before
            S_AGE: begin
                n_pend = 1'b0;
                if (r_cnt != WAYS_CNT) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_pend = 1'b1;
                    n_dway = r_cnt[WIX_W-1:0];
                end
                if (r_pend) begin
                    ram_we = 1'b1;
                    if (d_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            // hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_way   = r_find ? best_ext[VWAY_W-1:0] : '0;
                    n_out_flag  = r_find;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_set        <= n_set;
        r_way        <= n_way;
        r_stamp      <= n_stamp;
        r_draw       <= n_draw;
        r_cnt        <= n_cnt;
        r_dway       <= n_dway;
        r_best       <= n_best;
        r_best_stamp <= n_best_stamp;
        r_best_rrpv  <= n_best_rrpv;
        r_gap        <= n_gap;
        r_find       <= n_find;
        r_out_way    <= n_out_way;
        r_out_flag   <= n_out_flag;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_hit_prio  <= 1'b0;
            r_ins_prob  <= INS_PROB_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_hit_prio  <= n_hit_prio;
            r_ins_prob  <= n_ins_prob;
        end
    end

    // ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-VWAY_W){1'b0}}, r_out_way};
    assign m_axis_tuser  = r_out_flag;

    // checks
    `LOVS_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, s_accept, r_state != S_IDLE, "accepted transaction did not start work")
    `LOVS_ASSERT_SAME(a_no_write_idle, i_clk, i_rst_n, r_state == S_IDLE, !ram_we, "RAM write while idle")
    `LOVS_ASSERT_SAME(a_rw_apart, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "RAM read and write collide")
    `LOVS_ASSERT_SAME(a_plain_result_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "non-victim result carries a way")

endmodule

`default_nettype wire

[tb/tb_lru_or_brrip_victim_select_top.sv]
// ----------------------------------------------------------------------------
// Replacement victim select - testbench
// Streams invalidate, touch, insert and find-victim requests into the block
// under several register settings, in both LRU and bimodal RRIP modes, with
// random gaps on the request side and random stalls on the result side. A
// local model of the per-way stamps, RRPVs and valid bits predicts every
// result, and each result transaction is checked against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_or_brrip_victim_select_top;
    import lovs_pkg::*;

    localparam int RRPV_TOP = (1 << DEF_RRPV_BITS) - 1;
    localparam int PHASES   = 9;
    localparam int SETTLE   = 24;   // wait that covers the longest request, a find with ageing

    // One request as it travels on the slave side
    typedef struct packed {
        t_kind              kind;
        logic [SET_W-1:0]   set;
        logic [WAY_W-1:0]   way;
        logic [STAMP_W-1:0] stamp;
        logic [PCT_W-1:0]   pct;
    } t_req;

    // One result as it travels on the master side
    typedef struct packed {
        logic [VWAY_W-1:0] way;
        logic              ready;
    } t_victim;

    // Register settings per phase: policy, hit priority, insert probability
    int unsigned phase_cfg [PHASES][3] = '{
        '{0, 0, 3}, '{1, 0, 3}, '{1, 1, 100}, '{1, 0, 0}, '{0, 1, 127},
        '{1, 1, 127}, '{1, 0, 50}, '{0, 0, 64}, '{1, 0, 1}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [KIND_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Local copy of the replacement state and registers
    logic [STAMP_W-1:0] lru_stamp  [DEF_SETS][DEF_WAYS];
    int unsigned        rrpv       [DEF_SETS][DEF_WAYS];
    bit                 line_valid [DEF_SETS][DEF_WAYS];
    bit                 mode_rrip = 1'b0;
    bit                 hit_clear = 1'b0;
    logic [PCT_W-1:0]   ins_prob  = INS_PROB_RST;

    t_req        req_pending [$];
    t_req        req_cur;
    t_victim     victims_due [$];
    int unsigned reqs_queued = 0;
    int unsigned reqs_taken  = 0;
    int unsigned kind_seen [4] = '{0, 0, 0, 0};
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int          tx_gap = 0;
    int          rx_stall = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    logic [STAMP_W-1:0] stamp_clock = '0;

    lru_or_brrip_victim_select_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly none, some short, a few long
    function automatic int idle_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Time stamps mostly rise; some are random or tiny to force ties
    function automatic logic [STAMP_W-1:0] next_stamp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom();
        if (r == 1) return $urandom_range(0, 3);
        stamp_clock = stamp_clock + $urandom_range(1, 40);
        return stamp_clock;
    endfunction

    function automatic logic [PCT_W-1:0] next_pct();
        if ($urandom_range(0, 99) < 15) return PCT_W'($urandom_range(0, 127));
        return PCT_W'($urandom_range(1, 100));
    endfunction

    function automatic void queue_req(t_kind kind, int set, int way,
                                      logic [STAMP_W-1:0] stamp, int pct);
        t_req r;
        r.kind  = kind;
        r.set   = SET_W'(set);
        r.way   = WAY_W'(way);
        r.stamp = stamp;
        r.pct   = PCT_W'(pct);
        req_pending.push_back(r);
        reqs_queued++;
    endfunction

    // Apply one request to the local state and return the result it gives
    function automatic t_victim apply_request(t_req r);
        t_victim res;
        int      best;
        int      gap;
        int      sum;
        bit      hole;
        res = '0;
        if (r.kind == KIND_FIND) begin
            res.ready = 1'b1;
            best = 0;
            if (!mode_rrip) begin
                for (int w = 1; w < DEF_WAYS; w++)
                    if (lru_stamp[r.set][w] < lru_stamp[r.set][best]) best = w;
            end else begin
                hole = 1'b0;
                for (int w = 0; w < DEF_WAYS && !hole; w++) begin
                    if (!line_valid[r.set][w]) begin
                        best = w;
                        hole = 1'b1;
                    end else if (rrpv[r.set][w] > rrpv[r.set][best]) begin
                        best = w;
                    end
                end
                // age the whole set so the victim reaches the distant value
                if (!hole) begin
                    gap = RRPV_TOP - rrpv[r.set][best];
                    for (int w = 0; w < DEF_WAYS && gap > 0; w++) begin
                        sum = rrpv[r.set][w] + gap;
                        rrpv[r.set][w] = (sum > RRPV_TOP) ? RRPV_TOP : sum;
                    end
                end
            end
            res.way = VWAY_W'(best);
        end else if (!mode_rrip) begin
            lru_stamp[r.set][r.way] = (r.kind == KIND_INVAL) ? '0 : r.stamp;
        end else begin
            case (r.kind)
                KIND_INVAL: begin
                    line_valid[r.set][r.way] = 1'b0;
                end
                KIND_TOUCH: begin
                    if (hit_clear) rrpv[r.set][r.way] = 0;
                    else if (rrpv[r.set][r.way] > 0) rrpv[r.set][r.way]--;
                end
                default: begin
                    rrpv[r.set][r.way] = (r.pct <= ins_prob) ? RRPV_TOP - 1 : RRPV_TOP;
                    line_valid[r.set][r.way] = 1'b1;
                end
            endcase
        end
        return res;
    endfunction

    // Request driver: takes pending requests, predicts each one on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                victims_due.push_back(apply_request(req_cur));
                kind_seen[req_cur.kind]++;
                reqs_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_pending.size() != 0) begin
                    req_cur = req_pending.pop_front();
                    s_axis_tdata  <= {req_cur.pct, req_cur.stamp, req_cur.way, req_cur.set};
                    s_axis_tuser  <= req_cur.kind;
                    s_axis_tvalid <= 1'b1;
                    tx_gap = idle_len(tx_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each result transaction, stalls at random
    always @(posedge i_clk) begin
        t_victim due;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (victims_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    due = victims_due.pop_front();
                    results_checked++;
                    if (m_axis_tdata !== {{(M_TDATA_W-VWAY_W){1'b0}}, due.way}) begin
                        mismatches++;
                        $display("%0t: victim_way expected %0d, actual tdata %h",
                                 $time, due.way, m_axis_tdata);
                    end
                    if (m_axis_tuser !== due.ready) begin
                        mismatches++;
                        $display("%0t: victim_ready expected %b, actual %b",
                                 $time, due.ready, m_axis_tuser);
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_stall = idle_len(rx_calm);
            end
        end
    end

    // Stimulus sequencer
    initial begin
        int hot_sets [4];
        int set;
        int pick;

        for (int s = 0; s < DEF_SETS; s++)
            for (int w = 0; w < DEF_WAYS; w++) begin
                lru_stamp[s][w]  = '0;
                rrpv[s][w]       = 0;
                line_valid[s][w] = 1'b0;
            end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // wait until the block is idle before touching its registers
            while (reqs_taken != reqs_queued || victims_due.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
            if (ph != 0) begin
                @(posedge i_clk);
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= REG_POLICY;
                i_cfg_data <= CFG_DATA_W'(phase_cfg[ph][0]);
                @(posedge i_clk);
                i_cfg_idx  <= REG_HIT_PRIO;
                i_cfg_data <= CFG_DATA_W'(phase_cfg[ph][1]);
                @(posedge i_clk);
                i_cfg_idx  <= REG_INS_PROB;
                i_cfg_data <= CFG_DATA_W'(phase_cfg[ph][2]);
                @(posedge i_clk);
                i_cfg_we   <= 1'b0;
                mode_rrip = phase_cfg[ph][0][0];
                hit_clear = phase_cfg[ph][1][0];
                ins_prob  = PCT_W'(phase_cfg[ph][2]);
            end
            tx_calm = (ph == 2) || (ph == 7);
            rx_calm = (ph == 2) || (ph == 6);

            // LRU: extreme stamps, tie to lowest way, invalidate back to zero
            if (ph == 0) begin
                queue_req(KIND_INSERT, 0, 0, '1, 127);
                queue_req(KIND_TOUCH, 0, 1, 32'd5, 1);
                queue_req(KIND_FIND, 0, 0, '0, 1);
                queue_req(KIND_INVAL, 0, 1, '1, 100);
                queue_req(KIND_FIND, 0, 7, '0, 1);
                queue_req(KIND_INSERT, 63, 7, '0, 0);
                queue_req(KIND_FIND, 63, 7, '1, 127);
            end
            // RRIP: invalid way first, fill at long value, ageing, touch, hole
            if (ph == 1) begin
                queue_req(KIND_FIND, 5, 0, '0, 1);
                for (int w = 0; w < DEF_WAYS; w++)
                    queue_req(KIND_INSERT, 5, w, next_stamp(), (w % 2) ? 3 : 1);
                queue_req(KIND_FIND, 5, 0, '0, 1);
                queue_req(KIND_TOUCH, 5, 0, '0, 1);
                queue_req(KIND_FIND, 5, 0, '0, 1);
                queue_req(KIND_INVAL, 5, 4, '0, 1);
                queue_req(KIND_FIND, 5, 0, '0, 1);
            end

            // Random requests, mostly on a few hot sets so finds see history
            foreach (hot_sets[k]) hot_sets[k] = $urandom_range(0, DEF_SETS - 1);
            for (int n = 0; n < 210;) begin
                set = ($urandom_range(0, 99) < 75) ? hot_sets[$urandom_range(0, 3)]
                                                   : $urandom_range(0, DEF_SETS - 1);
                if ($urandom_range(0, 9) < 2) begin
                    // fill a whole set, then ask for a victim
                    for (int w = 0; w < DEF_WAYS; w++)
                        queue_req(KIND_INSERT, set, w, next_stamp(),
                                  ($urandom_range(0, 1) != 0) ? ins_prob : next_pct());
                    queue_req(KIND_FIND, set, $urandom_range(0, 7), next_stamp(),
                              next_pct());
                    n += DEF_WAYS + 1;
                end else begin
                    pick = $urandom_range(0, 99);
                    queue_req(pick < 15 ? KIND_INVAL : pick < 45 ? KIND_TOUCH :
                              pick < 75 ? KIND_INSERT : KIND_FIND,
                              set, $urandom_range(0, DEF_WAYS - 1), next_stamp(), next_pct());
                    n++;
                end
            end
        end

        // Drain and let the block settle
        while (reqs_taken != reqs_queued || victims_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d requests: %0d invalidate, %0d touch, %0d insert, %0d find",
                 reqs_taken, kind_seen[KIND_INVAL], kind_seen[KIND_TOUCH],
                 kind_seen[KIND_INSERT], kind_seen[KIND_FIND]);
        $display("over %0d register settings in both modes; %0d results checked",
                 PHASES, results_checked);
        if (mismatches == 0) begin
            $display("tb_lru_or_brrip_victim_select_top: PASS");
        end else begin
            $display("tb_lru_or_brrip_victim_select_top: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("tb_lru_or_brrip_victim_select_top: FAIL");
        $finish;
    end

endmodule
